@@ design/urcd_pkg.sv @@
// ----------------------------------------------------------------------------
// urcd_pkg
// shared types and byte codes for the remote command decoder
// ----------------------------------------------------------------------------
package urcd_pkg;

   // controller to datapath
   typedef struct packed {
      logic load;   // word accepted, decode it
      logic emit;   // load the output register
      logic last;   // the emitted word is the closing one of the run
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic wr_pending;   // a queue write is still to be emitted
   } dp_status_type;

   // received byte codes
   localparam logic [7:0] BYTE_ALT_TOP   = 8'd10;
   localparam logic [7:0] BYTE_SPEED_HI  = 8'h58;
   localparam logic [7:0] BYTE_SPEED_LO  = 8'h59;
   localparam logic [7:0] BYTE_HALT      = 8'h5A;
   localparam logic [7:0] BYTE_FWD       = 8'h41;
   localparam logic [7:0] BYTE_BACK      = 8'h45;
   localparam logic [7:0] BYTE_RIGHT_A   = 8'h42;
   localparam logic [7:0] BYTE_RIGHT_B   = 8'h43;
   localparam logic [7:0] BYTE_RIGHT_C   = 8'h44;
   localparam logic [7:0] BYTE_LEFT_A    = 8'h46;
   localparam logic [7:0] BYTE_LEFT_B    = 8'h47;
   localparam logic [7:0] BYTE_LEFT_C    = 8'h48;
   localparam logic [7:0] BYTE_CLR_QUEUE = 8'h61;
   localparam logic [7:0] BYTE_RESTART   = 8'h62;
   localparam logic [7:0] BYTE_PAUSE     = 8'h63;
   localparam logic [7:0] BYTE_CLR_ODD   = 8'h64;
   localparam logic [7:0] BYTE_APP_GAP   = 8'h65;
   localparam logic [7:0] BYTE_STOP      = 8'h66;
   localparam logic [7:0] BYTE_APP_LEFT  = 8'h67;
   localparam logic [7:0] BYTE_APP_FWD   = 8'h68;
   localparam logic [7:0] BYTE_APP_RIGHT = 8'h69;
   localparam logic [7:0] BYTE_JUMP      = 8'h6F;
   localparam logic [7:0] BYTE_OPEN      = 8'h7B;
   localparam logic [7:0] BYTE_CLOSE     = 8'h7D;
   localparam logic [7:0] BYTE_REPORT    = 8'h50;
   localparam logic [7:0] BYTE_ID_LO     = 8'h30;
   localparam logic [7:0] BYTE_ID_HI     = 8'h38;
   localparam logic [7:0] BYTE_ZERO      = 8'd48;

   // alternate code set, below ten
   localparam logic [7:0] ALT_FWD     = 8'd1;
   localparam logic [7:0] ALT_BACK    = 8'd5;
   localparam logic [7:0] ALT_RIGHT_A = 8'd2;
   localparam logic [7:0] ALT_RIGHT_B = 8'd4;
   localparam logic [7:0] ALT_LEFT_A  = 8'd6;
   localparam logic [7:0] ALT_LEFT_B  = 8'd8;

   // drive flags
   localparam logic [3:0] FLAGS_NONE  = 4'b0000;
   localparam logic [3:0] FLAGS_FWD   = 4'b0001;
   localparam logic [3:0] FLAGS_BACK  = 4'b0010;
   localparam logic [3:0] FLAGS_LEFT  = 4'b0100;
   localparam logic [3:0] FLAGS_RIGHT = 4'b1000;
   localparam logic [3:0] FLAGS_AXIAL = 4'b0011;

   localparam logic [1:0] SPEED_HIGH = 2'd1;
   localparam logic [1:0] SPEED_LOW  = 2'd2;

   localparam logic [1:0] RUN_NONE    = 2'd0;
   localparam logic [1:0] RUN_RESTART = 2'd1;
   localparam logic [1:0] RUN_JUMP    = 2'd2;

   localparam logic [2:0] QV_GAP   = 3'd0;
   localparam logic [2:0] QV_FWD   = 3'd1;
   localparam logic [2:0] QV_LEFT  = 3'd2;
   localparam logic [2:0] QV_RIGHT = 3'd3;
   localparam logic [2:0] QV_PAUSE = 3'd4;

   // queue layout
   localparam logic [6:0] Q_FIRST     = 7'd20;
   localparam logic [6:0] Q_PAUSE_SLOT = 7'd21;
   localparam logic [6:0] Q_RESTART_END = 7'd22;
   localparam logic [5:0] Q_APPEND_HOME = 6'd22;
   localparam logic [5:0] Q_PAUSE_MIN = 6'd19;

   // frame byte positions
   localparam logic [5:0] FRAME_POS_ID     = 6'd1;
   localparam logic [5:0] FRAME_POS_FOURTH = 6'd3;

endpackage

@@ design/urcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// urcd_ctrl
// sequencer: takes one byte, then walks the write run and the closing word
// ----------------------------------------------------------------------------
module urcd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  urcd_pkg::dp_status_type status,
   output urcd_pkg::ctrl_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic valid_ff, valid_in;
   logic slot_free;

   assign slot_free = !valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (!status.wr_pending) begin
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ design/urcd_dp.sv @@
// ----------------------------------------------------------------------------
// urcd_dp
// decoder state, queue write generator, frame folding and output register
// ----------------------------------------------------------------------------
module urcd_dp #(
   parameter int FRAME_BYTES = 50,
   parameter int QUEUE_END   = 60
) (
   input  logic                    clock,
   input  logic                    reset,
   input  urcd_pkg::ctrl_cmd_type  cmd,
   output urcd_pkg::dp_status_type status,
   input  logic [7:0]              req_rx_byte,
   input  logic [5:0]              req_runner_position,
   output logic [3:0]              rsp_drive_flags,
   output logic [1:0]              rsp_speed_mode,
   output logic                    rsp_stop_request,
   output logic                    rsp_queue_write_valid,
   output logic [5:0]              rsp_queue_write_index,
   output logic [2:0]              rsp_queue_write_value,
   output logic [1:0]              rsp_runner_command,
   output logic                    rsp_param_valid,
   output logic [3:0]              rsp_param_select,
   output logic signed [31:0]      rsp_param_value,
   output logic                    rsp_send_request,
   output logic                    rsp_last
);

   localparam logic [6:0] QEND     = 7'(QUEUE_END);
   localparam logic [6:0] AP_LIMIT = 7'(QUEUE_END - 2);
   localparam logic [5:0] FBYTES   = 6'(FRAME_BYTES);
   localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
   localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

   // decoder state
   logic [3:0] flags_ff, flags_in;
   logic [1:0] speed_ff, speed_in;
   logic [5:0] ap_ff, ap_in;
   logic       open_ff, open_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] fourth_ff, fourth_in;
   logic signed [31:0] fv_ff, fv_in;

   // write generator
   logic [6:0] cur_ff, cur_in;
   logic [6:0] lim_ff, lim_in;
   logic       step2_ff, step2_in;
   logic [6:0] mark_ff, mark_in;
   logic [2:0] mval_ff, mval_in;

   // closing word fields
   logic        stop_ff, stop_in;
   logic [1:0]  rcmd_ff, rcmd_in;
   logic        pvalid_ff, pvalid_in;
   logic [3:0]  psel_ff, psel_in;
   logic [31:0] pval_ff, pval_in;
   logic        send_ff, send_in;

   // output register
   logic [3:0]  o_flags_ff;
   logic [1:0]  o_speed_ff;
   logic        o_stop_ff;
   logic        o_qwv_ff;
   logic [5:0]  o_qidx_ff;
   logic [2:0]  o_qval_ff;
   logic [1:0]  o_rcmd_ff;
   logic        o_pvalid_ff;
   logic [3:0]  o_psel_ff;
   logic [31:0] o_pval_ff;
   logic        o_send_ff;
   logic        o_last_ff;

   logic [7:0] b;
   logic [6:0] tgt;
   logic [6:0] ap_end;
   logic signed [36:0] fv_ext, prod, digit, fold;
   logic closing, collecting;

   function automatic logic [6:0] min7(input logic [6:0] x, input logic [6:0] y);
      return (x < y) ? x : y;
   endfunction

   assign b      = req_rx_byte;
   assign tgt    = {1'b0, req_runner_position}
                   + (req_runner_position[0] ? 7'd2 : 7'd1);
   assign ap_end = {1'b0, ap_ff} + 7'd2;

   // value*10 + digit, widened so nothing wraps before the clamp
   assign fv_ext = 37'(fv_ff);
   assign prod   = (fv_ext <<< 3) + (fv_ext <<< 1);
   assign digit  = $signed({29'd0, b}) - $signed({29'd0, urcd_pkg::BYTE_ZERO});
   assign fold   = prod + digit;

   assign closing    = (b == urcd_pkg::BYTE_CLOSE);
   assign collecting = (b == urcd_pkg::BYTE_OPEN) || (open_ff && !closing);

   assign status.wr_pending = (cur_ff < lim_ff);

   always_comb begin
      flags_in  = flags_ff;
      speed_in  = speed_ff;
      ap_in     = ap_ff;
      open_in   = open_ff;
      cnt_in    = cnt_ff;
      id_in     = id_ff;
      fourth_in = fourth_ff;
      fv_in     = fv_ff;
      cur_in    = cur_ff;
      lim_in    = lim_ff;
      step2_in  = step2_ff;
      mark_in   = mark_ff;
      mval_in   = mval_ff;
      stop_in   = stop_ff;
      rcmd_in   = rcmd_ff;
      pvalid_in = pvalid_ff;
      psel_in   = psel_ff;
      pval_in   = pval_ff;
      send_in   = send_ff;

      if (cmd.load) begin
         // no writes unless a command sets them up
         cur_in    = '0;
         lim_in    = '0;
         step2_in  = 1'b0;
         mark_in   = '0;
         mval_in   = urcd_pkg::QV_GAP;
         stop_in   = 1'b0;
         rcmd_in   = urcd_pkg::RUN_NONE;
         pvalid_in = 1'b0;
         psel_in   = '0;
         pval_in   = '0;
         send_in   = 1'b0;

         if (b == urcd_pkg::BYTE_SPEED_LO) speed_in = urcd_pkg::SPEED_LOW;
         if (b == urcd_pkg::BYTE_SPEED_HI) speed_in = urcd_pkg::SPEED_HIGH;

         if (b > urcd_pkg::BYTE_ALT_TOP) begin
            case (b)
               urcd_pkg::BYTE_HALT: flags_in = urcd_pkg::FLAGS_NONE;
               urcd_pkg::BYTE_FWD:  flags_in = urcd_pkg::FLAGS_FWD;
               urcd_pkg::BYTE_BACK: flags_in = urcd_pkg::FLAGS_BACK;
               urcd_pkg::BYTE_RIGHT_A, urcd_pkg::BYTE_RIGHT_B, urcd_pkg::BYTE_RIGHT_C:
                  flags_in = urcd_pkg::FLAGS_RIGHT;
               urcd_pkg::BYTE_LEFT_A, urcd_pkg::BYTE_LEFT_B, urcd_pkg::BYTE_LEFT_C:
                  flags_in = urcd_pkg::FLAGS_LEFT;
               urcd_pkg::BYTE_CLR_QUEUE: begin
                  cur_in   = urcd_pkg::Q_FIRST;
                  lim_in   = QEND;
                  mark_in  = urcd_pkg::Q_PAUSE_SLOT;
                  mval_in  = urcd_pkg::QV_PAUSE;
                  rcmd_in  = urcd_pkg::RUN_RESTART;
                  ap_in    = urcd_pkg::Q_APPEND_HOME;
                  flags_in = flags_ff & urcd_pkg::FLAGS_AXIAL;
               end
               urcd_pkg::BYTE_RESTART: begin
                  cur_in   = urcd_pkg::Q_PAUSE_SLOT;
                  lim_in   = min7(urcd_pkg::Q_RESTART_END, QEND);
                  rcmd_in  = urcd_pkg::RUN_RESTART;
                  flags_in = flags_ff & urcd_pkg::FLAGS_AXIAL;
               end
               urcd_pkg::BYTE_PAUSE: begin
                  if (req_runner_position > urcd_pkg::Q_PAUSE_MIN) begin
                     cur_in  = tgt;
                     lim_in  = min7(tgt + 7'd1, QEND);
                     mark_in = tgt;
                     mval_in = urcd_pkg::QV_PAUSE;
                  end
               end
               urcd_pkg::BYTE_CLR_ODD: begin
                  cur_in   = urcd_pkg::Q_PAUSE_SLOT;
                  lim_in   = QEND;
                  step2_in = 1'b1;
               end
               urcd_pkg::BYTE_APP_GAP, urcd_pkg::BYTE_APP_LEFT,
               urcd_pkg::BYTE_APP_FWD, urcd_pkg::BYTE_APP_RIGHT: begin
                  cur_in  = {1'b0, ap_ff};
                  lim_in  = min7(ap_end, QEND);
                  mark_in = {1'b0, ap_ff};
                  case (b)
                     urcd_pkg::BYTE_APP_LEFT:  mval_in = urcd_pkg::QV_LEFT;
                     urcd_pkg::BYTE_APP_FWD:   mval_in = urcd_pkg::QV_FWD;
                     urcd_pkg::BYTE_APP_RIGHT: mval_in = urcd_pkg::QV_RIGHT;
                     default:                  mval_in = urcd_pkg::QV_GAP;
                  endcase
                  if ({1'b0, ap_ff} < AP_LIMIT) ap_in = ap_end[5:0];
               end
               urcd_pkg::BYTE_STOP: stop_in = 1'b1;
               urcd_pkg::BYTE_JUMP: rcmd_in = urcd_pkg::RUN_JUMP;
               default: flags_in = urcd_pkg::FLAGS_NONE;
            endcase
         end

         if (b < urcd_pkg::BYTE_ALT_TOP) begin
            speed_in = urcd_pkg::SPEED_HIGH;
            if (b == urcd_pkg::ALT_FWD) begin
               flags_in = urcd_pkg::FLAGS_FWD;
            end else if (b == urcd_pkg::ALT_BACK) begin
               flags_in = urcd_pkg::FLAGS_BACK;
            end else if (b inside {[urcd_pkg::ALT_RIGHT_A:urcd_pkg::ALT_RIGHT_B]}) begin
               flags_in = urcd_pkg::FLAGS_RIGHT;
            end else if (b inside {[urcd_pkg::ALT_LEFT_A:urcd_pkg::ALT_LEFT_B]}) begin
               flags_in = urcd_pkg::FLAGS_LEFT;
            end else begin
               flags_in = urcd_pkg::FLAGS_NONE;
            end
         end

         // parameter frame
         if (closing) begin
            if (fourth_ff == urcd_pkg::BYTE_REPORT) begin
               send_in = 1'b1;
            end else if (id_ff inside {[urcd_pkg::BYTE_ID_LO:urcd_pkg::BYTE_ID_HI]}) begin
               pvalid_in = 1'b1;
               psel_in   = 4'(id_ff - urcd_pkg::BYTE_ID_LO);
               pval_in   = fv_ff;
            end
            open_in   = 1'b0;
            cnt_in    = '0;
            id_in     = '0;
            fourth_in = '0;
            fv_in     = '0;
         end else if (collecting) begin
            open_in = 1'b1;
            if (cnt_ff < FBYTES) begin
               if (cnt_ff == urcd_pkg::FRAME_POS_ID) id_in = b;
               if (cnt_ff == urcd_pkg::FRAME_POS_FOURTH) fourth_in = b;
               if (cnt_ff >= urcd_pkg::FRAME_POS_FOURTH) begin
                  if (fold > SAT_HI) begin
                     fv_in = SAT_HI[31:0];
                  end else if (fold < SAT_LO) begin
                     fv_in = SAT_LO[31:0];
                  end else begin
                     fv_in = fold[31:0];
                  end
               end
               cnt_in = cnt_ff + 6'd1;
            end
         end
      end else if (cmd.emit && !cmd.last) begin
         cur_in = cur_ff + (step2_ff ? 7'd2 : 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= urcd_pkg::FLAGS_NONE;
         speed_ff  <= urcd_pkg::SPEED_LOW;
         ap_ff     <= urcd_pkg::Q_APPEND_HOME;
         open_ff   <= 1'b0;
         cnt_ff    <= '0;
         id_ff     <= '0;
         fourth_ff <= '0;
         fv_ff     <= '0;
         cur_ff    <= '0;
         lim_ff    <= '0;
      end else begin
         flags_ff  <= flags_in;
         speed_ff  <= speed_in;
         ap_ff     <= ap_in;
         open_ff   <= open_in;
         cnt_ff    <= cnt_in;
         id_ff     <= id_in;
         fourth_ff <= fourth_in;
         fv_ff     <= fv_in;
         cur_ff    <= cur_in;
         lim_ff    <= lim_in;
      end
   end

   always_ff @(posedge clock) begin
      step2_ff  <= step2_in;
      mark_ff   <= mark_in;
      mval_ff   <= mval_in;
      stop_ff   <= stop_in;
      rcmd_ff   <= rcmd_in;
      pvalid_ff <= pvalid_in;
      psel_ff   <= psel_in;
      pval_ff   <= pval_in;
      send_ff   <= send_in;
   end

   // output register, a write word or the closing word
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_flags_ff <= flags_ff;
         o_speed_ff <= speed_ff;
         o_last_ff  <= cmd.last;
         if (cmd.last) begin
            o_stop_ff   <= stop_ff;
            o_qwv_ff    <= 1'b0;
            o_qidx_ff   <= '0;
            o_qval_ff   <= urcd_pkg::QV_GAP;
            o_rcmd_ff   <= rcmd_ff;
            o_pvalid_ff <= pvalid_ff;
            o_psel_ff   <= psel_ff;
            o_pval_ff   <= pval_ff;
            o_send_ff   <= send_ff;
         end else begin
            o_stop_ff   <= 1'b0;
            o_qwv_ff    <= 1'b1;
            o_qidx_ff   <= cur_ff[5:0];
            o_qval_ff   <= (cur_ff == mark_ff) ? mval_ff : urcd_pkg::QV_GAP;
            o_rcmd_ff   <= urcd_pkg::RUN_NONE;
            o_pvalid_ff <= 1'b0;
            o_psel_ff   <= '0;
            o_pval_ff   <= '0;
            o_send_ff   <= 1'b0;
         end
      end
   end

   assign rsp_drive_flags       = o_flags_ff;
   assign rsp_speed_mode        = o_speed_ff;
   assign rsp_stop_request      = o_stop_ff;
   assign rsp_queue_write_valid = o_qwv_ff;
   assign rsp_queue_write_index = o_qidx_ff;
   assign rsp_queue_write_value = o_qval_ff;
   assign rsp_runner_command    = o_rcmd_ff;
   assign rsp_param_valid       = o_pvalid_ff;
   assign rsp_param_select      = o_psel_ff;
   assign rsp_param_value       = $signed(o_pval_ff);
   assign rsp_send_request      = o_send_ff;
   assign rsp_last              = o_last_ff;

endmodule

@@ design/uart_remote_command_decoder_top.sv @@
// ----------------------------------------------------------------------------
// uart_remote_command_decoder_top
// remote-control byte decoder with action queue writes and parameter frames
// ----------------------------------------------------------------------------
// result words: one word per cycle while the result side does not stall
// each byte gives W write words and then its closing word, W the number of
//   queue writes it causes (queue clear gives QUEUE_END - 20 writes); the
//   write generator issues one queue write per cycle unless the result side
//   stalls, and the next byte waits until the closing word is loaded
// reset: synchronous; flags cleared, low speed, append slot 22, frame idle
// ----------------------------------------------------------------------------
module uart_remote_command_decoder_top #(
   parameter int FRAME_BYTES = 50,   // stored frame bytes, 8 to 63
   parameter int QUEUE_END   = 60    // action queue length, 24 to 64
) (
   input  logic               clock,
   input  logic               reset,
   // byte channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic [5:0]         req_runner_position,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_drive_flags,
   output logic [1:0]         rsp_speed_mode,
   output logic               rsp_stop_request,
   output logic               rsp_queue_write_valid,
   output logic [5:0]         rsp_queue_write_index,
   output logic [2:0]         rsp_queue_write_value,
   output logic [1:0]         rsp_runner_command,
   output logic               rsp_param_valid,
   output logic [3:0]         rsp_param_select,
   output logic signed [31:0] rsp_param_value,
   output logic               rsp_send_request,
   output logic               rsp_last
);

   // command and status between sequencer and datapath
   urcd_pkg::ctrl_cmd_type  cmd;
   urcd_pkg::dp_status_type status;

   // sequencer: idle takes a byte, run walks the write words and then the
   // closing word; the byte side is freed once the closing word is loaded into
   // the output register, even if it still waits to be taken
   urcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: the whole decode happens on the load cycle, leaving a small
   // write generator (start, limit, stride, marked entry) for the run
   urcd_dp #(
      .FRAME_BYTES (FRAME_BYTES),
      .QUEUE_END   (QUEUE_END)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_rx_byte           (req_rx_byte),
      .req_runner_position   (req_runner_position),
      .rsp_drive_flags       (rsp_drive_flags),
      .rsp_speed_mode        (rsp_speed_mode),
      .rsp_stop_request      (rsp_stop_request),
      .rsp_queue_write_valid (rsp_queue_write_valid),
      .rsp_queue_write_index (rsp_queue_write_index),
      .rsp_queue_write_value (rsp_queue_write_value),
      .rsp_runner_command    (rsp_runner_command),
      .rsp_param_valid       (rsp_param_valid),
      .rsp_param_select      (rsp_param_select),
      .rsp_param_value       (rsp_param_value),
      .rsp_send_request      (rsp_send_request),
      .rsp_last              (rsp_last)
   );

   // a taken byte always keeps the sequencer busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer not busy after taking a byte");

   // while the byte side is open, the write generator must be spent
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !status.wr_pending)
      else $error("queue writes left over when the next byte may enter");

   // queue writes never point past the end of the queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_queue_write_valid) |->
         ({1'b0, rsp_queue_write_index} < 7'(QUEUE_END)))
      else $error("queue write beyond queue end");

endmodule
